>>> hw/rtl/ffa_pkg.sv
// Shared types and constants for the first-fit free-list allocator.
`timescale 1ns / 1ps

package ffa_pkg;

  localparam int ADDR_W    = 13;
  localparam int NEED_W    = 15;
  localparam int HDR_BYTES = 8;
  localparam int MIN_BLOCK = 16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // latch request, start walk at list head
    logic do_free;  // push block onto list head
    logic advance;  // step to next list entry
    logic take;     // unlink current entry and return it
    logic carve;    // carve a new block at the break pointer
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_end;
    logic fit;
  } sts_t;

  // Block size for a carved block: request rounded up to 8 plus header, min 16.
  function automatic logic [NEED_W-1:0] need_bytes(input logic [ADDR_W-1:0] req);
    logic [NEED_W-2:0] r;
    r = ({1'b0, req} + (NEED_W-1)'(HDR_BYTES - 1)) & ~(NEED_W-1)'(HDR_BYTES - 1);
    if (r > (NEED_W-1)'(HDR_BYTES)) begin
      return {1'b0, r} + NEED_W'(HDR_BYTES);
    end else begin
      return NEED_W'(MIN_BLOCK);
    end
  endfunction

endpackage

>>> hw/rtl/ffa_ctrl.sv
// Controller state machine for the first-fit free-list allocator.
`timescale 1ns / 1ps

module ffa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          op,
  input  ffa_pkg::sts_t sts,
  output ffa_pkg::cmd_t cmd,
  output logic          busy
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_CARVE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (op == ffa_pkg::OP_FREE) begin
            cmd.do_free = 1'b1;
          end else begin
            cmd.accept = 1'b1;
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (sts.walk_end) begin
          state_next = S_CARVE;
        end else if (sts.fit) begin
          cmd.take   = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_CARVE: begin
        cmd.carve  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

>>> hw/rtl/ffa_datapath.sv
// Datapath for the first-fit free-list allocator: header memories, list walk, break pointer.
`timescale 1ns / 1ps

module ffa_datapath #(
  parameter int HEAP_BYTES = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ffa_pkg::cmd_t              cmd,
  input  logic [ffa_pkg::ADDR_W-1:0] req_size,
  input  logic [ffa_pkg::ADDR_W-1:0] address,
  output ffa_pkg::sts_t              sts,
  output logic [ffa_pkg::ADDR_W-1:0] result_addr,
  output logic                       ok,
  output logic                       done
);

  localparam int SLOT_COUNT = HEAP_BYTES / ffa_pkg::HDR_BYTES;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int LINK_W     = $clog2(SLOT_COUNT + 1);
  localparam int BP_W       = $clog2(HEAP_BYTES + 1);
  localparam int SUM_W      = ((BP_W > ffa_pkg::NEED_W) ? BP_W : ffa_pkg::NEED_W) + 1;
  localparam int CMP_W      = (BP_W > ffa_pkg::ADDR_W) ? BP_W : ffa_pkg::ADDR_W;
  localparam int RA_W       = ((LINK_W + 4 > BP_W + 1) ? LINK_W + 4 : BP_W + 1)
                              + ffa_pkg::ADDR_W;
  localparam int FIDX_W     = ffa_pkg::ADDR_W - 3;
  localparam logic [LINK_W-1:0] LIST_EMPTY = LINK_W'(SLOT_COUNT);

  logic [BP_W-1:0]   size_mem [SLOT_COUNT];
  logic [LINK_W-1:0] link_mem [SLOT_COUNT];

  logic [BP_W-1:0]             break_pointer;
  logic [LINK_W-1:0]           list_head;
  logic [LINK_W-1:0]           cur;
  logic [LINK_W-1:0]           prev;
  logic [LINK_W-1:0]           steps;
  logic [ffa_pkg::ADDR_W-1:0]  req;
  logic [ffa_pkg::NEED_W-1:0]  need;
  logic [BP_W-1:0]             rd_size;
  logic [LINK_W-1:0]           rd_link;

  logic [IDX_W-1:0]            rd_idx;
  logic [ffa_pkg::ADDR_W-1:0]  free_off;
  logic [FIDX_W-1:0]           free_idx;
  logic                        free_valid;
  logic [SUM_W-1:0]            carve_end;
  logic                        carve_fits;
  logic [IDX_W-1:0]            bp_idx;
  logic [RA_W-1:0]             take_addr;
  logic [RA_W-1:0]             carve_addr;

  logic                        lw_en;
  logic [IDX_W-1:0]            lw_idx;
  logic [LINK_W-1:0]           lw_data;

  assign free_off   = address - ffa_pkg::ADDR_W'(ffa_pkg::HDR_BYTES);
  assign free_idx   = free_off[ffa_pkg::ADDR_W-1:3];
  assign free_valid = (address >= ffa_pkg::ADDR_W'(ffa_pkg::HDR_BYTES))
                      && (32'(free_idx) < SLOT_COUNT);

  assign carve_end  = SUM_W'(break_pointer) + SUM_W'(need);
  assign carve_fits = carve_end <= SUM_W'(HEAP_BYTES);
  assign bp_idx     = IDX_W'(break_pointer >> 3);

  assign take_addr  = RA_W'({cur, 3'b000}) + RA_W'(ffa_pkg::HDR_BYTES);
  assign carve_addr = RA_W'(break_pointer) + RA_W'(ffa_pkg::HDR_BYTES);

  assign sts.walk_end = (cur >= LIST_EMPTY) || (steps >= LINK_W'(SLOT_COUNT));
  assign sts.fit      = CMP_W'(rd_size) >= CMP_W'(req);

  always_comb begin
    if (cmd.accept) begin
      rd_idx = list_head[IDX_W-1:0];
    end else if (cmd.advance) begin
      rd_idx = rd_link[IDX_W-1:0];
    end else begin
      rd_idx = cur[IDX_W-1:0];
    end
  end

  always_comb begin
    lw_en   = 1'b0;
    lw_idx  = cur[IDX_W-1:0];
    lw_data = rd_link;
    if (cmd.do_free && free_valid) begin
      lw_en   = 1'b1;
      lw_idx  = IDX_W'(free_idx);
      lw_data = list_head;
    end else if (cmd.take && (prev < LIST_EMPTY)) begin
      lw_en   = 1'b1;
      lw_idx  = prev[IDX_W-1:0];
      lw_data = rd_link;
    end else if (cmd.carve && carve_fits) begin
      lw_en   = 1'b1;
      lw_idx  = bp_idx;
      lw_data = LIST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    rd_size <= size_mem[rd_idx];
    rd_link <= link_mem[rd_idx];
    if (lw_en) begin
      link_mem[lw_idx] <= lw_data;
    end
    if (cmd.carve && carve_fits) begin
      size_mem[bp_idx] <= BP_W'(need);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req   <= req_size;
      need  <= ffa_pkg::need_bytes(req_size);
      cur   <= list_head;
      prev  <= LIST_EMPTY;
      steps <= '0;
    end else if (cmd.advance) begin
      prev  <= cur;
      cur   <= rd_link;
      steps <= steps + LINK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      break_pointer <= '0;
      list_head     <= LIST_EMPTY;
      done          <= 1'b0;
    end else begin
      done <= cmd.do_free || cmd.take || cmd.carve;
      if (cmd.do_free && free_valid) begin
        list_head <= LINK_W'(free_idx);
      end else if (cmd.take && (prev >= LIST_EMPTY)) begin
        list_head <= rd_link;
      end
      if (cmd.carve && carve_fits) begin
        break_pointer <= carve_end[BP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_free) begin
      result_addr <= '0;
      ok          <= free_valid;
    end else if (cmd.take) begin
      result_addr <= take_addr[ffa_pkg::ADDR_W-1:0];
      ok          <= 1'b1;
    end else if (cmd.carve) begin
      result_addr <= carve_fits ? carve_addr[ffa_pkg::ADDR_W-1:0] : '0;
      ok          <= carve_fits;
    end
  end

endmodule

>>> hw/rtl/first_fit_free_list_allocator.sv
// Top level of the first-fit free-list heap allocator.
//
//   transaction  handshake          payload
//   request      start & !busy      op, req_size, address
//   result       done (one cycle)   result_addr, ok
//
// A free is performed at the accepting edge; done is registered and rises in the cycle after.
// An allocate is accepted from idle, then examines free-list entries
// one per cycle through the header memory read port, and carves a new
// block at the break pointer when no entry fits.
// Synchronous reset empties the heap and the free list; no clearing pass.
// The receiver cannot stall: a result is valid only in its done cycle.
`timescale 1ns / 1ps

module first_fit_free_list_allocator #(
  parameter int HEAP_BYTES = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       op,
  input  logic [ffa_pkg::ADDR_W-1:0] req_size,
  input  logic [ffa_pkg::ADDR_W-1:0] address,
  output logic                       done,
  output logic [ffa_pkg::ADDR_W-1:0] result_addr,
  output logic                       ok
);

  ffa_pkg::cmd_t cmd;
  ffa_pkg::sts_t sts;

  ffa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  ffa_datapath #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req_size    (req_size),
    .address     (address),
    .sts         (sts),
    .result_addr (result_addr),
    .ok          (ok),
    .done        (done)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_free_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == ffa_pkg::OP_FREE) |=> (done && result_addr == '0))
    else $error("free transaction did not complete in one cycle");

  a_fail_null: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (result_addr == '0))
    else $error("failed transaction returned nonzero address");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.do_free, cmd.advance, cmd.take, cmd.carve}))
    else $error("conflicting datapath commands");

endmodule
